@@ hw/rtl/sbusfd_pkg.sv @@
// shared types, constants and channel functions for the sbus frame decoder
package sbusfd_pkg;

  localparam int FrameBytes = 25;
  localparam int StoreDepth = 24;
  localparam int PosW       = $clog2(FrameBytes);
  localparam int ChanW      = 11;
  localparam int StickCount = 6;
  localparam int SwCount    = 4;

  localparam logic [7:0] HeaderByte = 8'h0F;
  localparam logic [7:0] FooterByte = 8'h00;

  localparam logic signed [1:0] SwAbove  = 2'sb11;
  localparam logic signed [1:0] SwBelow  = 2'sb01;
  localparam logic signed [1:0] SwCentre = 2'sb00;

  // above centre: floor((220*v + 130) / 261) through a reciprocal of 2^26 / 261
  localparam int            PosShift = 26;
  localparam int            PosRecip = 257123;
  localparam logic [25:0]   PosMul   = 26'(220 * PosRecip);
  localparam logic [39:0]   PosOff   = 40'(130 * PosRecip);
  // below centre: floor((169050 - 165*u) / 196) - 862 through 2^25 / 196
  localparam int            NegShift = 25;
  localparam int            NegRecip = 171197;
  localparam logic [25:0]   NegMul   = 26'(165 * NegRecip);
  localparam logic [39:0]   NegOff   = 40'(169050) * 40'(NegRecip);
  localparam logic [10:0]   NegBias  = 11'd862;
  localparam logic [10:0]   Centre   = 11'd1024;

  typedef struct packed {
    logic [StickCount-1:0][ChanW-1:0] stick;
    logic [SwCount-1:0][ChanW-1:0]    sw;
    logic                             lost;
    logic                             fsafe;
  } raw_frame_t;

  function automatic logic [ChanW-1:0] chan_field(logic [23:0] w, logic [2:0] sh);
    return w[sh +: ChanW];
  endfunction

  function automatic logic signed [ChanW-1:0] scale_stick(logic [ChanW-1:0] c);
    logic [ChanW-1:0] mag;
    logic [36:0]      term;
    logic [39:0]      acc;
    logic [39:0]      q;
    if (c[ChanW-1]) begin
      mag  = {1'b0, c[ChanW-2:0]};
      term = 37'(mag) * 37'(PosMul);
      acc  = PosOff + 40'(term);
      q    = acc >> PosShift;
      return q[ChanW-1:0];
    end else begin
      mag  = Centre - {1'b0, c[ChanW-2:0]};
      term = 37'(mag) * 37'(NegMul);
      acc  = NegOff - 40'(term);
      q    = acc >> NegShift;
      return q[ChanW-1:0] - NegBias;
    end
  endfunction

  function automatic logic signed [1:0] switch_sign(logic [ChanW-1:0] c);
    if (!c[ChanW-1]) begin
      return SwBelow;
    end else if (|c[ChanW-2:0]) begin
      return SwAbove;
    end else begin
      return SwCentre;
    end
  endfunction

endpackage

@@ hw/rtl/sbusfd_assembler.sv @@
// byte position tracking, frame store, header and footer check, raw channel register
module sbusfd_assembler (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   byte_valid,
  output logic                   byte_stall,
  input  logic [7:0]             data_byte,
  input  logic                   frame_start,
  output logic                   raw_valid,
  input  logic                   raw_stall,
  output sbusfd_pkg::raw_frame_t raw
);

  logic [sbusfd_pkg::PosW-1:0] byte_position;
  logic [sbusfd_pkg::PosW-1:0] byte_position_next;
  logic                        in_frame;
  logic                        in_frame_next;
  logic [7:0]                  frame_store [sbusfd_pkg::StoreDepth];
  logic                        accept;
  logic                        active;
  logic                        store_beat;
  logic                        last_beat;
  logic                        good;
  logic [sbusfd_pkg::PosW-1:0] pos_eff;
  sbusfd_pkg::raw_frame_t      raw_next;

  assign byte_stall = raw_valid && raw_stall;
  assign accept     = byte_valid && !byte_stall;
  assign pos_eff    = frame_start ? '0 : byte_position;
  assign active     = accept && (frame_start || in_frame);
  assign store_beat = active && (pos_eff < sbusfd_pkg::PosW'(sbusfd_pkg::StoreDepth));
  assign last_beat  = active && !store_beat;
  assign good       = last_beat && (frame_store[0] == sbusfd_pkg::HeaderByte)
                      && (data_byte == sbusfd_pkg::FooterByte);

  always_comb begin
    byte_position_next = byte_position;
    in_frame_next      = in_frame;
    if (store_beat) begin
      byte_position_next = pos_eff + 1'b1;
      in_frame_next      = 1'b1;
    end else if (last_beat) begin
      byte_position_next = '0;
      in_frame_next      = 1'b0;
    end
  end

  always_comb begin
    raw_next.stick[0] = sbusfd_pkg::chan_field({8'h00, frame_store[2], frame_store[1]}, 3'd0);
    raw_next.stick[1] = sbusfd_pkg::chan_field({8'h00, frame_store[3], frame_store[2]}, 3'd3);
    raw_next.stick[2] = sbusfd_pkg::chan_field(
                          {frame_store[5], frame_store[4], frame_store[3]}, 3'd6);
    raw_next.stick[3] = sbusfd_pkg::chan_field({8'h00, frame_store[6], frame_store[5]}, 3'd1);
    raw_next.stick[4] = sbusfd_pkg::chan_field({8'h00, frame_store[7], frame_store[6]}, 3'd4);
    raw_next.stick[5] = sbusfd_pkg::chan_field(
                          {frame_store[9], frame_store[8], frame_store[7]}, 3'd7);
    raw_next.sw[0]    = sbusfd_pkg::chan_field({8'h00, frame_store[10], frame_store[9]}, 3'd2);
    raw_next.sw[1]    = sbusfd_pkg::chan_field({8'h00, frame_store[11], frame_store[10]}, 3'd5);
    raw_next.sw[2]    = sbusfd_pkg::chan_field({8'h00, frame_store[13], frame_store[12]}, 3'd0);
    raw_next.sw[3]    = sbusfd_pkg::chan_field({8'h00, frame_store[14], frame_store[13]}, 3'd3);
    raw_next.lost     = frame_store[23][2];
    raw_next.fsafe    = frame_store[23][3];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      in_frame      <= 1'b0;
    end else begin
      byte_position <= byte_position_next;
      in_frame      <= in_frame_next;
    end
  end

  always_ff @(posedge clk) begin
    if (store_beat) begin
      frame_store[pos_eff] <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_valid <= 1'b0;
    end else if (good) begin
      raw_valid <= 1'b1;
    end else if (!raw_stall) begin
      raw_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (good) begin
      raw <= raw_next;
    end
  end

  a_idle_pos_zero: assert property (@(posedge clk) disable iff (rst)
    !in_frame |-> byte_position == '0)
    else $error("byte position not cleared outside a frame");

  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    byte_position <= sbusfd_pkg::PosW'(sbusfd_pkg::StoreDepth))
    else $error("byte position past last byte");

  a_good_loads_raw: assert property (@(posedge clk) disable iff (rst)
    good |=> raw_valid)
    else $error("good frame did not reach raw register");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    raw_valid && raw_stall |-> !good)
    else $error("held raw frame overwritten");

endmodule

@@ hw/rtl/sbusfd_scaler.sv @@
// channel scaling, switch reduction and result register
module sbusfd_scaler (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   raw_valid,
  output logic                   raw_stall,
  input  sbusfd_pkg::raw_frame_t raw,
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic signed [10:0]     stick_a,
  output logic signed [10:0]     stick_b,
  output logic signed [10:0]     stick_c,
  output logic signed [10:0]     stick_d,
  output logic signed [10:0]     aux_e,
  output logic signed [10:0]     aux_f,
  output logic signed [1:0]      switch_one,
  output logic signed [1:0]      switch_two,
  output logic signed [1:0]      switch_three,
  output logic signed [1:0]      switch_four,
  output logic                   lost_frame,
  output logic                   fail_safe
);

  logic take;

  assign raw_stall = result_valid && result_stall;
  assign take      = raw_valid && !raw_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      stick_a      <= sbusfd_pkg::scale_stick(raw.stick[0]);
      stick_b      <= sbusfd_pkg::scale_stick(raw.stick[1]);
      stick_c      <= sbusfd_pkg::scale_stick(raw.stick[2]);
      stick_d      <= sbusfd_pkg::scale_stick(raw.stick[3]);
      aux_e        <= sbusfd_pkg::scale_stick(raw.stick[4]);
      aux_f        <= sbusfd_pkg::scale_stick(raw.stick[5]);
      switch_one   <= sbusfd_pkg::switch_sign(raw.sw[0]);
      switch_two   <= sbusfd_pkg::switch_sign(raw.sw[1]);
      switch_three <= sbusfd_pkg::switch_sign(raw.sw[2]);
      switch_four  <= sbusfd_pkg::switch_sign(raw.sw[3]);
      lost_frame   <= raw.lost;
      fail_safe    <= raw.fsafe;
    end
  end

  a_take_loads: assert property (@(posedge clk) disable iff (rst)
    take |=> result_valid)
    else $error("raw frame taken but no result");

  a_switch_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> switch_one != 2'sb10 && switch_two != 2'sb10
                     && switch_three != 2'sb10 && switch_four != 2'sb10)
    else $error("switch code out of range");

  a_stalled_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(stick_a) && $stable(fail_safe))
    else $error("stalled result changed");

endmodule

@@ hw/rtl/sbus_frame_decoder_top.sv @@
// SBUS frame decoder: takes one receiver byte per beat and gives one decoded frame
// per good 25-byte frame. A byte can be taken in every cycle while byte_stall is low;
// a beat on frame_start begins a new frame at byte 0 and drops any partial one. Bytes
// 0..23 go into a register store, byte 24 closes the frame: with header 0x0F and
// footer 0x00 the raw channels are latched into a raw register, and from there they
// are scaled into the result register once it holds no stalled result. The six stick
// channels are centred at 1024 and scaled to -862..+862 over the 11-bit range, the
// four switch channels come out as -1, 0 or +1, with the lost and failsafe flags of
// byte 23. Bad frames and bytes outside a frame give nothing. Only a result held
// under stall while another one waits in the raw register stalls the byte input.
module sbus_frame_decoder_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  output logic               byte_stall,
  input  logic [7:0]         data_byte,
  input  logic               frame_start,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [10:0] stick_a,
  output logic signed [10:0] stick_b,
  output logic signed [10:0] stick_c,
  output logic signed [10:0] stick_d,
  output logic signed [10:0] aux_e,
  output logic signed [10:0] aux_f,
  output logic signed [1:0]  switch_one,
  output logic signed [1:0]  switch_two,
  output logic signed [1:0]  switch_three,
  output logic signed [1:0]  switch_four,
  output logic               lost_frame,
  output logic               fail_safe
);

  logic                   raw_valid;
  logic                   raw_stall;
  sbusfd_pkg::raw_frame_t raw;

  sbusfd_assembler u_assembler (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_stall  (byte_stall),
    .data_byte   (data_byte),
    .frame_start (frame_start),
    .raw_valid   (raw_valid),
    .raw_stall   (raw_stall),
    .raw         (raw)
  );

  sbusfd_scaler u_scaler (
    .clk          (clk),
    .rst          (rst),
    .raw_valid    (raw_valid),
    .raw_stall    (raw_stall),
    .raw          (raw),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .stick_a      (stick_a),
    .stick_b      (stick_b),
    .stick_c      (stick_c),
    .stick_d      (stick_d),
    .aux_e        (aux_e),
    .aux_f        (aux_f),
    .switch_one   (switch_one),
    .switch_two   (switch_two),
    .switch_three (switch_three),
    .switch_four  (switch_four),
    .lost_frame   (lost_frame),
    .fail_safe    (fail_safe)
  );

endmodule
